>>> rtl/u8sd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by every module of the decoder.
`default_nettype none

package u8sd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 31;
    localparam int unsigned ST_W    = 2;
    localparam int unsigned LEN_W   = 3;
    localparam int unsigned RAW_W   = 24;
    localparam int unsigned CFG_W   = 3;
    localparam int unsigned APB_W   = 32;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned OUT_W   = 40;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_UTF = 2'd1;
    localparam logic [ST_W-1:0] ST_BOM     = 2'd2;

    // Register index of the length limit
    localparam logic [0:0] REG_MAX_SEQ_LEN = 1'b0;

    localparam logic [RAW_W-1:0] BOM_BYTES = 24'hEFBBBF;
    localparam logic [CP_W-1:0]  BOM_CP    = 31'h0000FEFF;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [ST_W-1:0]  status;
        logic [LEN_W-1:0] seq_len;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/u8sd_cfg.sv
// APB-style register holding the sequence length limit.
// Depends on u8sd_pkg.
`default_nettype none

module u8sd_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [u8sd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [u8sd_pkg::APB_W-1:0]  pwdata,
    output logic      [u8sd_pkg::APB_W-1:0]  prdata,
    output logic                             pready,
    output logic      [u8sd_pkg::CFG_W-1:0]  max_seq_len
);
    import u8sd_pkg::*;

    logic [CFG_W-1:0] max_seq_len_reg;
    logic             hit;

    // Word index is the top address bit; the low two bits are the byte offset
    assign hit    = (paddr[ADDR_W-1] == REG_MAX_SEQ_LEN);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_seq_len_reg <= '0;
        end
        else if (psel && penable && pwrite && hit)
        begin
            max_seq_len_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (hit)
        begin
            prdata = {{(APB_W-CFG_W){1'b0}}, max_seq_len_reg};
        end
    end

    assign max_seq_len = max_seq_len_reg;

endmodule

`default_nettype wire

>>> rtl/u8sd_core.sv
// Input register, sequence state and per-byte decode of the UTF-8 stream.
// Depends on u8sd_pkg; feeds results into u8sd_out.
`default_nettype none

module u8sd_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [u8sd_pkg::BYTE_W-1:0] in_byte,
    output logic                             in_ready,
    input  wire logic [u8sd_pkg::CFG_W-1:0]  max_seq_len,
    input  wire logic                        out_space,
    output logic                             res_push,
    output u8sd_pkg::result_t                res
);
    import u8sd_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    logic [LEN_W-1:0]  expected_len_reg, expected_len_next;
    logic [LEN_W-1:0]  bytes_seen_reg,   bytes_seen_next;
    logic [CP_W-1:0]   payload_acc_reg,  payload_acc_next;
    logic [RAW_W-1:0]  raw_acc_reg,      raw_acc_next;

    logic              advance;
    logic              res_valid;
    logic [LEN_W-1:0]  head_len;
    logic [4:0]        head_bits;
    logic              head_ok;
    logic [LEN_W-1:0]  seen_inc;
    logic [RAW_W-1:0]  raw_shift;
    logic [CP_W-1:0]   pay_shift;
    logic [BYTE_W-1:0] b;

    assign b        = in_byte_reg;
    assign advance  = in_valid_reg && out_space;
    assign in_ready = !in_valid_reg || out_space;
    assign res_push = advance && res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_len_reg <= '0;
            bytes_seen_reg   <= '0;
            payload_acc_reg  <= '0;
            raw_acc_reg      <= '0;
        end
        else if (advance)
        begin
            expected_len_reg <= expected_len_next;
            bytes_seen_reg   <= bytes_seen_next;
            payload_acc_reg  <= payload_acc_next;
            raw_acc_reg      <= raw_acc_next;
        end
    end

    // Length announced by a head byte and its payload bits
    always_comb
    begin
        head_ok   = 1'b1;
        head_len  = 3'd2;
        head_bits = b[4:0];
        if (b[7:5] == 3'b110)
        begin
            head_len  = 3'd2;
            head_bits = b[4:0];
        end
        else if (b[7:4] == 4'b1110)
        begin
            head_len  = 3'd3;
            head_bits = {1'b0, b[3:0]};
        end
        else if (b[7:3] == 5'b11110)
        begin
            head_len  = 3'd4;
            head_bits = {2'b00, b[2:0]};
        end
        else if (b[7:2] == 6'b111110)
        begin
            head_len  = 3'd5;
            head_bits = {3'b000, b[1:0]};
        end
        else if (b[7:1] == 7'b1111110)
        begin
            head_len  = 3'd6;
            head_bits = {4'b0000, b[0]};
        end
        else
        begin
            head_ok = 1'b0;
        end
    end

    assign seen_inc  = bytes_seen_reg + 3'd1;
    assign raw_shift = {raw_acc_reg[RAW_W-BYTE_W-1:0], b};
    assign pay_shift = {payload_acc_reg[CP_W-7:0], b[5:0]};

    always_comb
    begin
        expected_len_next = expected_len_reg;
        bytes_seen_next   = bytes_seen_reg;
        payload_acc_next  = payload_acc_reg;
        raw_acc_next      = raw_acc_reg;
        res_valid         = 1'b0;
        res.code_point    = '0;
        res.status        = ST_OK;
        res.seq_len       = 3'd1;

        if (expected_len_reg == '0)
        begin
            if (!b[7] || max_seq_len == 3'd1)
            begin
                res_valid      = 1'b1;
                res.code_point = {{(CP_W-BYTE_W){1'b0}}, b};
            end
            else if (!head_ok || (max_seq_len != '0 && max_seq_len < head_len))
            begin
                res_valid  = 1'b1;
                res.status = ST_NOT_UTF;
            end
            else
            begin
                // Open a sequence
                expected_len_next = head_len;
                bytes_seen_next   = 3'd1;
                payload_acc_next  = {{(CP_W-5){1'b0}}, head_bits};
                raw_acc_next      = {{(RAW_W-BYTE_W){1'b0}}, b};
            end
        end
        else if (b[7:6] != 2'b10)
        begin
            // Bad tail byte: consume it and drop the partial sequence
            res_valid         = 1'b1;
            res.status        = ST_NOT_UTF;
            res.seq_len       = seen_inc;
            expected_len_next = '0;
            bytes_seen_next   = '0;
            payload_acc_next  = '0;
            raw_acc_next      = '0;
        end
        else if (seen_inc >= expected_len_reg)
        begin
            res_valid         = 1'b1;
            res.seq_len       = seen_inc;
            res.code_point    = pay_shift;
            if (expected_len_reg == 3'd3 && raw_shift == BOM_BYTES)
            begin
                res.code_point = BOM_CP;
                res.status     = ST_BOM;
            end
            expected_len_next = '0;
            bytes_seen_next   = '0;
            payload_acc_next  = '0;
            raw_acc_next      = '0;
        end
        else
        begin
            bytes_seen_next  = seen_inc;
            payload_acc_next = pay_shift;
            raw_acc_next     = raw_shift;
        end
    end

endmodule

`default_nettype wire

>>> rtl/u8sd_out.sv
// Two-entry result buffer between the decode stage and the output stream.
// Depends on u8sd_pkg.
`default_nettype none

module u8sd_out (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire u8sd_pkg::result_t push_data,
    output logic                   space,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output u8sd_pkg::result_t      out_data
);
    import u8sd_pkg::*;

    localparam logic [1:0] FULL = 2'd2;

    result_t    entry_reg [2];
    logic [1:0] count_reg;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       pop;

    assign space     = (count_reg != FULL);
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign out_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/utf8_stream_decoder.sv
// Top level of the streaming UTF-8 decoder (up to six-byte forms, 31-bit values).
// Depends on u8sd_pkg, u8sd_cfg, u8sd_core and u8sd_out.
//
//  Channel   Direction  Handshake             Payload
//  s_axis    in         s_tvalid/s_tready     one encoded byte
//  m_axis    out        m_tvalid/m_tready     code point, length, status
//  apb       in         psel/penable/pready   max_seq_len at byte address 0
//
// One byte is taken per cycle while the input register is empty or the buffer
// has space. A byte is held in the input register, decoded against the sequence
// state and written to a two-entry buffer; its result, if any, is offered on
// m_axis once it has been written to the buffer.
// The buffer decouples m_tready from s_tready, so a stalled result costs no
// input cycle until both entries are full. Reset clears the open sequence
// and sets the limit to zero (any length).
`default_nettype none

module utf8_stream_decoder (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [u8sd_pkg::BYTE_W-1:0] s_tdata,  // [7:0] in_byte
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [u8sd_pkg::OUT_W-1:0]  m_tdata,  // [30:0] code_point, [33:31] seq_len
    output logic      [u8sd_pkg::ST_W-1:0]   m_tuser,  // [1:0] status
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [u8sd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [u8sd_pkg::APB_W-1:0]  pwdata,
    output logic      [u8sd_pkg::APB_W-1:0]  prdata,
    output logic                             pready
);
    import u8sd_pkg::*;

    logic [CFG_W-1:0] max_seq_len;
    logic             out_space;
    logic             res_push;
    result_t          res;
    result_t          out_res;

    u8sd_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .max_seq_len (max_seq_len)
    );

    u8sd_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_byte     (s_tdata),
        .in_ready    (s_tready),
        .max_seq_len (max_seq_len),
        .out_space   (out_space),
        .res_push    (res_push),
        .res         (res)
    );

    u8sd_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res),
        .space     (out_space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {{(OUT_W-CP_W-LEN_W){1'b0}}, out_res.seq_len, out_res.code_point};
    assign m_tuser = out_res.status;

endmodule

`default_nettype wire

>>> verif/utf8_decode_checker.sv
// Scoreboard for the UTF-8 stream decoder: tracks the limit register, decodes every
// accepted byte alongside the block and checks each code point result in order.
// Depends on u8sd_pkg for field widths and status codes.
`timescale 1ns / 1ps

module utf8_decode_checker
    import u8sd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [BYTE_W-1:0]   s_tdata,   // [7:0] in_byte
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [OUT_W-1:0]    m_tdata,   // [30:0] code_point, [33:31] seq_len
    input  logic [ST_W-1:0]     m_tuser,   // [1:0] status
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [APB_W-1:0]    pwdata,
    input  logic                pready,
    input  logic                drained,
    output int                  errors,
    output int                  pending
);

    result_t          expected_points[$];
    logic [CFG_W-1:0] len_limit;
    logic [LEN_W-1:0] open_len;
    logic [LEN_W-1:0] got;
    logic [CP_W-1:0]  bits_acc;
    logic [RAW_W-1:0] last3;
    logic             leftovers_done;

    function automatic void add_expect(input logic [CP_W-1:0] cp, input logic [ST_W-1:0] st,
                                       input logic [LEN_W-1:0] n);
        result_t r;
        r.code_point = cp;
        r.status     = st;
        r.seq_len    = n;
        expected_points.push_back(r);
    endfunction

    function automatic void close_seq();
        open_len = '0;
        got      = '0;
        bits_acc = '0;
        last3    = '0;
    endfunction

    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] n;
        logic [7:0]       head_bits;
        if (open_len == 0) begin
            if (b < 8'h80 || len_limit == 3'd1) begin
                add_expect(CP_W'(b), ST_OK, 3'd1);
                return;
            end
            n = 3'd0;
            if (b[7:5] == 3'b110) begin n = 3'd2; head_bits = b & 8'h1F; end
            else if (b[7:4] == 4'b1110) begin n = 3'd3; head_bits = b & 8'h0F; end
            else if (b[7:3] == 5'b11110) begin n = 3'd4; head_bits = b & 8'h07; end
            else if (b[7:2] == 6'b111110) begin n = 3'd5; head_bits = b & 8'h03; end
            else if (b[7:1] == 7'b1111110) begin n = 3'd6; head_bits = b & 8'h01; end
            // continuation byte, FE or FF as head, or head over the limit
            if (n == 0 || (len_limit != 0 && len_limit < n)) begin
                add_expect('0, ST_NOT_UTF, 3'd1);
                return;
            end
            open_len = n;
            got      = 3'd1;
            bits_acc = CP_W'(head_bits);
            last3    = RAW_W'(b);
            return;
        end
        got   = got + 3'd1;
        last3 = {last3[15:0], b};
        if (b[7:6] != 2'b10) begin
            n = got;
            close_seq();
            add_expect('0, ST_NOT_UTF, n);
            return;
        end
        bits_acc = {bits_acc[CP_W-7:0], b[5:0]};
        if (got >= open_len) begin
            n = got;
            if (open_len == 3'd3 && last3 == BOM_BYTES)
                add_expect(BOM_CP, ST_BOM, n);
            else
                add_expect(bits_acc, ST_OK, n);
            close_seq();
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            expected_points.delete();
            len_limit      = '0;
            leftovers_done = 1'b0;
            errors         = 0;
            pending        = 0;
            close_seq();
        end
        else begin
            // a result leaves only after its byte has passed the input register, so compare first
            if (m_tvalid && m_tready) begin
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected result: code point %h, status %0d, length %0d",
                             $time, m_tdata[CP_W-1:0], m_tuser, m_tdata[CP_W+LEN_W-1:CP_W]);
                    errors++;
                end
                else begin
                    want = expected_points.pop_front();
                    if (m_tdata[CP_W-1:0] !== want.code_point) begin
                        $display("%0t: code point mismatch: expected %h, got %h",
                                 $time, want.code_point, m_tdata[CP_W-1:0]);
                        errors++;
                    end
                    if (m_tuser !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata[CP_W+LEN_W-1:CP_W] !== want.seq_len) begin
                        $display("%0t: length mismatch: expected %0d, got %0d",
                                 $time, want.seq_len, m_tdata[CP_W+LEN_W-1:CP_W]);
                        errors++;
                    end
                end
            end
            if (psel && penable && pwrite && pready && (paddr >> 2) == REG_MAX_SEQ_LEN)
                len_limit = pwdata[CFG_W-1:0];
            if (s_tvalid && s_tready)
                decode_byte(s_tdata);
            if (drained && !leftovers_done) begin
                foreach (expected_points[i])
                    $display("%0t: missing result: code point %h, status %0d, length %0d",
                             $time, expected_points[i].code_point,
                             expected_points[i].status, expected_points[i].seq_len);
                errors += expected_points.size();
                leftovers_done = 1'b1;
            end
            pending = expected_points.size();
        end
    end

endmodule

>>> verif/tb_utf8_stream_decoder.sv
// Top of the UTF-8 stream decoder testbench: clock, reset, byte and APB stimulus.
// Depends on u8sd_pkg, utf8_stream_decoder and utf8_decode_checker.
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;
    import u8sd_pkg::*;

    typedef logic [BYTE_W-1:0] byte_q_t[$];

    localparam logic [ADDR_W-1:0] ADDR_LIMIT  = {REG_MAX_SEQ_LEN, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_UNUSED = 3'd4;   // register index 1, not implemented
    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_BYTES   = 90;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic [ST_W-1:0]   m_tuser;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [APB_W-1:0]  pwdata   = '0;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    logic drained  = 1'b0;
    logic no_gaps  = 1'b0;
    logic hold_on  = 1'b0;
    int   errors;
    int   pending;
    int   bytes_sent = 0;
    int   stall_cnt  = 0;
    event hold_kick;

    utf8_stream_decoder u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    utf8_decode_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .drained  (drained),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side: random back-pressure, none in quiet phases, full back-pressure while held
    always @(posedge clk)
    begin
        if (hold_on)
            m_tready <= 1'b0;
        else if (no_gaps)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(99) >= 24);
    end

    initial
    begin
        forever
        begin
            @(hold_kick);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_on <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt == STALL_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (!no_gaps && $urandom_range(99) < 24)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_bytes(input byte_q_t bytes);
        foreach (bytes[i])
            send_byte(bytes[i]);
    endtask

    // hold the input quiet until every result is back, then let the pipeline drain
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= ($urandom & 32'hFFFF_FFF8) | APB_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly well-formed characters of every length, plus byte order marks,
    // sequences cut short by a non-tail byte, and raw noise
    task automatic send_random_char();
        byte_q_t           seq;
        logic [BYTE_W-1:0] head;
        int                kind;
        int                n;
        int                cut;
        kind = $urandom_range(99);
        if (kind < 8)
            seq = '{8'hEF, 8'hBB, 8'hBF};
        else if (kind < 90)
        begin
            n = (kind < 45) ? $urandom_range(1, 3) : $urandom_range(1, 6);
            if (kind >= 78 && n == 1)
                n = 2;
            if (n == 1)
                head = BYTE_W'($urandom_range(0, 127));
            else
                head = (8'hFF << (8 - n)) | (BYTE_W'($urandom) & (8'hFF >> (n + 1)));
            seq.push_back(head);
            cut = (kind >= 78) ? $urandom_range(1, n - 1) : n;
            for (int i = 1; i < cut; i++)
                seq.push_back(8'h80 | BYTE_W'($urandom_range(0, 63)));
            if (kind >= 78)
                seq.push_back($urandom_range(1) ? BYTE_W'($urandom_range(0, 127))
                                                : BYTE_W'($urandom_range(8'hC0, 8'hFF)));
        end
        else
            seq.push_back(BYTE_W'($urandom_range(0, 255)));
        send_bytes(seq);
    endtask

    initial
    begin
        byte_q_t          seq;
        logic [CFG_W-1:0] limits[9];
        int               goal;
        limits = '{3'd0, 3'd0, 3'd6, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd7};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // limit from reset: any length
        seq = '{8'h00, 8'hFF, 8'hFE, 8'h80,
                8'hC0, 8'h80,                              // overlong
                8'hEF, 8'hBB, 8'hBF,                       // byte order mark
                8'hF0, 8'h9F, 8'h98, 8'h80,
                8'hF8, 8'h88, 8'h80, 8'h80, 8'h80,
                8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,  // largest value
                8'hE1, 8'h41};                             // bad tail
        send_bytes(seq);
        settle();

        write_reg(ADDR_LIMIT, 3'd1);
        seq = '{8'hC3, 8'h80, 8'hFF, 8'h41};
        send_bytes(seq);
        settle();

        // open a four-byte sequence, then tighten the limit under it
        write_reg(ADDR_LIMIT, 3'd0);
        seq = '{8'hF0};
        send_bytes(seq);
        settle();
        write_reg(ADDR_LIMIT, 3'd2);
        seq = '{8'h9F, 8'h98, 8'h80, 8'hE2, 8'h82, 8'hC3, 8'hA9};
        send_bytes(seq);
        settle();

        // a write to the unused register must leave the limit alone
        write_reg(ADDR_UNUSED, 3'd1);
        seq = '{8'hC3, 8'hA9, 8'hF0};
        send_bytes(seq);
        settle();

        for (int p = 0; p < 9; p++)
        begin
            write_reg(ADDR_LIMIT, limits[p]);
            no_gaps <= (p == 5);
            if (p == 1)
                -> hold_kick;
            goal = bytes_sent + PHASE_BYTES;
            while (bytes_sent < goal)
                send_random_char();
            settle();
        end
        no_gaps <= 1'b0;

        drained <= 1'b1;
        repeat (3) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
